// ----- src/nvfm_pkg.sv -----
// Shared types and constants for the navigation variance failsafe monitor.
// Depends on nothing; the top level imports it.
package nvfm_pkg;

    localparam int unsigned VarW     = 16;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned CountW   = 4;
    localparam int unsigned IntervalW = 20;
    localparam int unsigned CfgDataW = 20;
    localparam int unsigned CfgIdxW  = 2;

    // Register indexes on the configuration port.
    localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_ACTION    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_LIMIT     = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_INTERVAL  = 2'd3;

    // Register reset values.
    localparam logic [VarW-1:0]      THRESHOLD_RST = 16'd205;
    localparam logic [1:0]           ACTION_RST    = 2'd0;
    localparam logic [CountW-1:0]    LIMIT_RST     = 4'd10;
    localparam logic [IntervalW-1:0] INTERVAL_RST  = 20'd30000;

    // Failsafe action register codes.
    localparam logic [1:0] FS_ACT_LAND      = 2'd0;
    localparam logic [1:0] FS_ACT_ALT_HOLD  = 2'd1;
    localparam logic [1:0] FS_ACT_LAND_STAB = 2'd2;

    // Variance source codes.
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_COMPASS  = 2'd1;
    localparam logic [1:0] KIND_VELOCITY = 2'd2;
    localparam logic [1:0] KIND_POSITION = 2'd3;

    // Result codes.
    localparam logic [1:0] VEV_NONE  = 2'd0;
    localparam logic [1:0] VEV_BAD   = 2'd1;
    localparam logic [1:0] VEV_CLEAR = 2'd2;

    localparam logic [1:0] FEV_NONE     = 2'd0;
    localparam logic [1:0] FEV_ENTER    = 2'd1;
    localparam logic [1:0] FEV_RESOLVED = 2'd2;

    localparam logic [1:0] REQ_NONE     = 2'd0;
    localparam logic [1:0] REQ_ALT_HOLD = 2'd1;
    localparam logic [1:0] REQ_LAND     = 2'd2;

    localparam logic [2:0] WARN_NONE    = 3'd0;
    localparam logic [2:0] WARN_GENERIC = 3'd4;

    // One input beat as it travels down the pipeline.
    typedef struct packed {
        logic             origin_valid;
        logic             armed;
        logic             usb_present;
        logic             position_ok;
        logic [VarW-1:0]  mag_var_x;
        logic [VarW-1:0]  mag_var_y;
        logic [VarW-1:0]  mag_var_z;
        logic [VarW-1:0]  vel_var;
        logic [VarW-1:0]  pos_variance;
        logic [TimeW-1:0] now_ms;
        logic             mode_is_land;
        logic             mode_needs_gps;
    } tick_t;

endpackage

// ----- src/nav_variance_failsafe_monitor_top.sv -----
// Navigation variance failsafe monitor: 2-of-3 variance vote with a hysteresis counter.
// Pipeline: input register, square stage, result; out_valid comes from the result stage.
// Throughput: one beat per cycle; the tick state updates in the result stage, so back-to-back
// ticks see each other's effects in order. An output stall freezes all three stages.
// Reset (rst_n low, asynchronous): pipeline empty, counter/flags/kind/last warning time zero,
// registers at threshold 205, action land, limit 10, warning interval 30000 ms.
module nav_variance_failsafe_monitor_top
    import nvfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,

    // Input channel.
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 origin_valid,
    input  logic                 armed,
    input  logic                 usb_present,
    input  logic                 position_ok,
    input  logic [VarW-1:0]      mag_var_x,
    input  logic [VarW-1:0]      mag_var_y,
    input  logic [VarW-1:0]      mag_var_z,
    input  logic [VarW-1:0]      vel_var,
    input  logic [VarW-1:0]      pos_variance,
    input  logic [TimeW-1:0]     now_ms,
    input  logic                 mode_is_land,
    input  logic                 mode_needs_gps,

    // Result channel.
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 tick_done,
    output logic                 ekf_bad,
    output logic                 failsafe_on,
    output logic [1:0]           variance_event,
    output logic [1:0]           failsafe_event,
    output logic [1:0]           action_request,
    output logic [2:0]           warn_kind
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are only expected while the
    // pipeline is empty, so no interlock against in-flight beats.
    // ------------------------------------------------------------------
    logic [VarW-1:0]      threshold_reg;
    logic [1:0]           action_reg;
    logic [CountW-1:0]    limit_reg;
    logic [IntervalW-1:0] interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            action_reg    <= ACTION_RST;
            limit_reg     <= LIMIT_RST;
            interval_reg  <= INTERVAL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[VarW-1:0];
                REG_ACTION:    action_reg    <= cfg_data[1:0];
                REG_LIMIT:     limit_reg     <= cfg_data[CountW-1:0];
                REG_INTERVAL:  interval_reg  <= cfg_data[IntervalW-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. The whole pipe moves together whenever the result
    // register is empty or being drained, which keeps the state update in
    // the last stage strictly in beat order.
    // ------------------------------------------------------------------
    logic advance;
    logic out_valid_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // Stage 1: input register.
    tick_t in_tick;
    tick_t s1_tick_reg;
    logic  s1_valid_reg;

    always_comb
    begin
        in_tick.origin_valid   = origin_valid;
        in_tick.armed          = armed;
        in_tick.usb_present    = usb_present;
        in_tick.position_ok    = position_ok;
        in_tick.mag_var_x      = mag_var_x;
        in_tick.mag_var_y      = mag_var_y;
        in_tick.mag_var_z      = mag_var_z;
        in_tick.vel_var        = vel_var;
        in_tick.pos_variance   = pos_variance;
        in_tick.now_ms         = now_ms;
        in_tick.mode_is_land   = mode_is_land;
        in_tick.mode_needs_gps = mode_needs_gps;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s1_tick_reg <= in_tick;
    end

    // Stage 2: squares of the compass components and of the threshold.
    // Each is a separate 16x16 product, registered before the sum.
    tick_t                s2_tick_reg;
    logic                 s2_valid_reg;
    logic [2*VarW-1:0]    sq_x_reg;
    logic [2*VarW-1:0]    sq_y_reg;
    logic [2*VarW-1:0]    sq_z_reg;
    logic [2*VarW-1:0]    sq_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_tick_reg <= s1_tick_reg;
            sq_x_reg    <= (2*VarW)'(s1_tick_reg.mag_var_x) * (2*VarW)'(s1_tick_reg.mag_var_x);
            sq_y_reg    <= (2*VarW)'(s1_tick_reg.mag_var_y) * (2*VarW)'(s1_tick_reg.mag_var_y);
            sq_z_reg    <= (2*VarW)'(s1_tick_reg.mag_var_z) * (2*VarW)'(s1_tick_reg.mag_var_z);
            sq_t_reg    <= (2*VarW)'(threshold_reg) * (2*VarW)'(threshold_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: votes, hysteresis counter and flags. The tick state is
    // updated at the same edge that loads the result register.
    // ------------------------------------------------------------------
    logic [CountW-1:0] counter_reg,  counter_next;
    logic              bad_reg,      bad_next;
    logic [1:0]        kind_reg,     kind_next;
    logic [TimeW-1:0]  last_warn_reg, last_warn_next;
    logic              fs_reg,       fs_next;

    logic              done_next;
    logic [1:0]        vev_next;
    logic [1:0]        fev_next;
    logic [1:0]        req_next;
    logic [2:0]        warn_next;

    logic              tick_done_reg;
    logic              ekf_bad_reg;
    logic              failsafe_on_reg;
    logic [1:0]        vev_reg;
    logic [1:0]        fev_reg;
    logic [1:0]        req_reg;
    logic [2:0]        warn_reg;

    // Vote and decision terms.
    logic [2*VarW+1:0] mag_sum;
    logic              mag_vote;
    logic              vel_vote;
    logic              pos_vote;
    logic              two_votes;
    logic              bad_tick;
    logic              reset_path;
    logic [1:0]        kind_voted;
    logic [CountW:0]   count_inc;
    logic [CountW-1:0] count_dec;
    logic [TimeW-1:0]  since_warn;
    logic              fs_mode_ok;

    always_comb
    begin
        mag_sum  = (2*VarW+2)'(sq_x_reg) + (2*VarW+2)'(sq_y_reg) + (2*VarW+2)'(sq_z_reg);
        mag_vote = mag_sum >= (2*VarW+2)'(sq_t_reg);
        vel_vote = s2_tick_reg.vel_var >= threshold_reg;
        pos_vote = s2_tick_reg.pos_variance >= threshold_reg;
        two_votes = (mag_vote && vel_vote) || (mag_vote && pos_vote) || (vel_vote && pos_vote);

        // A position source that is not usable counts as a bad tick and
        // leaves the recorded source alone.
        bad_tick   = !s2_tick_reg.position_ok || two_votes;
        reset_path = !s2_tick_reg.armed || s2_tick_reg.usb_present ||
                     (threshold_reg == '0);

        // The last passing vote, in compass/velocity/position order, wins.
        if (!s2_tick_reg.position_ok)
            kind_voted = kind_reg;
        else if (pos_vote)
            kind_voted = KIND_POSITION;
        else if (vel_vote)
            kind_voted = KIND_VELOCITY;
        else if (mag_vote)
            kind_voted = KIND_COMPASS;
        else
            kind_voted = kind_reg;

        count_inc  = {1'b0, counter_reg} + (CountW+1)'(1);
        count_dec  = counter_reg - CountW'(1);
        since_warn = s2_tick_reg.now_ms - last_warn_reg;
        fs_mode_ok = s2_tick_reg.mode_is_land || s2_tick_reg.mode_needs_gps ||
                     (action_reg == FS_ACT_LAND_STAB);

        counter_next   = counter_reg;
        bad_next       = bad_reg;
        kind_next      = kind_reg;
        last_warn_next = last_warn_reg;
        fs_next        = fs_reg;
        done_next      = 1'b0;
        vev_next       = VEV_NONE;
        fev_next       = FEV_NONE;
        req_next       = REQ_NONE;
        warn_next      = WARN_NONE;

        if (s2_tick_reg.origin_valid)
        begin
            done_next = 1'b1;
            if (reset_path)
            begin
                counter_next = '0;
                bad_next     = 1'b0;
                kind_next    = KIND_NONE;
                if (fs_reg)
                begin
                    fs_next  = 1'b0;
                    fev_next = FEV_RESOLVED;
                end
            end
            else
            begin
                kind_next = kind_voted;
                if (bad_tick)
                begin
                    if (!bad_reg)
                    begin
                        if (count_inc >= {1'b0, limit_reg})
                        begin
                            // Limit reached: latch bad and maybe raise failsafe.
                            counter_next = limit_reg;
                            bad_next     = 1'b1;
                            vev_next     = VEV_BAD;
                            if (since_warn > TimeW'(interval_reg))
                            begin
                                warn_next      = (kind_voted == KIND_NONE) ?
                                                 WARN_GENERIC : {1'b0, kind_voted};
                                last_warn_next = s2_tick_reg.now_ms;
                            end
                            if (!fs_reg && fs_mode_ok)
                            begin
                                fs_next  = 1'b1;
                                fev_next = FEV_ENTER;
                                req_next = (action_reg == FS_ACT_ALT_HOLD) ?
                                           REQ_ALT_HOLD : REQ_LAND;
                            end
                        end
                        else
                        begin
                            counter_next = count_inc[CountW-1:0];
                        end
                    end
                end
                else if (counter_reg != '0)
                begin
                    counter_next = count_dec;
                    if (bad_reg && (count_dec == '0))
                    begin
                        bad_next  = 1'b0;
                        kind_next = KIND_NONE;
                        vev_next  = VEV_CLEAR;
                        if (fs_reg)
                        begin
                            fs_next  = 1'b0;
                            fev_next = FEV_RESOLVED;
                        end
                    end
                end
            end
        end
    end

    // Tick state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            bad_reg       <= 1'b0;
            kind_reg      <= KIND_NONE;
            last_warn_reg <= '0;
            fs_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                counter_reg   <= counter_next;
                bad_reg       <= bad_next;
                kind_reg      <= kind_next;
                last_warn_reg <= last_warn_next;
                fs_reg        <= fs_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tick_done_reg   <= done_next;
            ekf_bad_reg     <= bad_next;
            failsafe_on_reg <= fs_next;
            vev_reg         <= vev_next;
            fev_reg         <= fev_next;
            req_reg         <= req_next;
            warn_reg        <= warn_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tick_done      = tick_done_reg;
    assign ekf_bad        = ekf_bad_reg;
    assign failsafe_on    = failsafe_on_reg;
    assign variance_event = vev_reg;
    assign failsafe_event = fev_reg;
    assign action_request = req_reg;
    assign warn_kind      = warn_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Failsafe is only ever raised together with the bad latch, and every
    // path that clears bad also clears failsafe.
    a_fs_implies_bad: assert property (@(posedge clk) disable iff (!rst_n)
        fs_reg |-> bad_reg)
        else $error("failsafe active without the bad latch");

    // A skipped tick reports no events, requests or warnings.
    a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tick_done_reg) |->
            (vev_reg == VEV_NONE) && (fev_reg == FEV_NONE) &&
            (req_reg == REQ_NONE) && (warn_reg == WARN_NONE))
        else $error("skipped tick carries an event");

    // Variance events agree with the reported flag.
    a_vev_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((vev_reg != VEV_BAD) || ekf_bad_reg) &&
            ((vev_reg != VEV_CLEAR) || !ekf_bad_reg))
        else $error("variance event disagrees with ekf_bad");

    // Failsafe entry always comes with an action request and a bad latch.
    a_enter_request: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (fev_reg == FEV_ENTER)) |->
            (req_reg != REQ_NONE) && (vev_reg == VEV_BAD) && failsafe_on_reg)
        else $error("failsafe entry without request");

    // A warning is only issued in the beat that latches bad.
    a_warn_on_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (warn_reg != WARN_NONE)) |-> (vev_reg == VEV_BAD))
        else $error("warning outside a bad latch");

endmodule
